// File: design/psl_pkg.sv
package psl_pkg;

   // token kinds
   localparam logic [5:0] SYM_BASE     = 6'd19;
   localparam logic [5:0] KIND_COLON   = 6'd24;
   localparam logic [5:0] KIND_ASSIGN  = 6'd31;
   localparam logic [5:0] KIND_IDENT   = 6'd32;
   localparam logic [5:0] KIND_NUMBER  = 6'd33;
   localparam logic [5:0] KIND_ECHO    = 6'd34;
   localparam logic [5:0] KIND_ERROR   = 6'd35;

   // error kinds
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_MALFORMED = 2'd1;
   localparam logic [1:0] ERR_SYMBOL    = 2'd2;

   // character codes
   localparam logic [7:0] CH_NL      = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;
   localparam logic [7:0] CH_DIGIT_0 = 8'd48;
   localparam logic [7:0] CH_DIGIT_9 = 8'd57;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam int NUM_SYMBOLS  = 12;
   localparam int NUM_RESERVED = 19;
   localparam int RSV_CHARS    = 9;

   localparam logic [7:0] SYM_CHARS [NUM_SYMBOLS] = '{
      8'h2E, 8'h3B, 8'h2C, 8'h28, 8'h29, 8'h3A, 8'h3D, 8'h3C, 8'h3E, 8'h2B, 8'h2D, 8'h2A
   };

   // reserved words, left aligned and padded with spaces: char j sits at element [8-j]
   localparam logic [RSV_CHARS-1:0][7:0] RSV_TEXT [NUM_RESERVED] = '{
      "program  ", "integer  ", "label    ", "var      ", "procedure",
      "function ", "begin    ", "end      ", "if       ", "then     ",
      "else     ", "while    ", "do       ", "or       ", "and      ",
      "div      ", "not      ", "read     ", "write    "
   };

   localparam logic [4:0] RSV_LEN [NUM_RESERVED] = '{
      5'd7, 5'd7, 5'd5, 5'd3, 5'd9, 5'd8, 5'd5, 5'd3, 5'd2, 5'd4,
      5'd4, 5'd5, 5'd2, 5'd2, 5'd3, 5'd3, 5'd3, 5'd4, 5'd5
   };

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUMBER,
      MODE_COLON
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [15:0] ident_number;
      logic [7:0]  echo_char;
      logic [1:0]  error_kind;
      logic [15:0] line_number;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] ident;
      logic [7:0]  echo;
      logic [1:0]  err;
   } token_type;

   // everything one character produces: one or two tokens on the same line
   typedef struct packed {
      logic        two;
      token_type   tok0;
      token_type   tok1;
      logic [15:0] line;
   } step_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } sym_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } kw_type;

   function automatic sym_type sym_lookup(input logic [7:0] c);
      sym_type r;
      r = '0;
      for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
         if (c == SYM_CHARS[i]) begin
            r.hit = 1'b1;
            r.idx = 4'(i);
         end
      end
      return r;
   endfunction

   function automatic kw_type kw_lookup(input logic [RSV_CHARS-1:0][7:0] w,
                                        input logic [4:0] len);
      kw_type r;
      logic   m;
      r = '0;
      for (int i = 0; i < NUM_RESERVED; i++) begin
         m = (len == RSV_LEN[i]);
         for (int j = 0; j < RSV_CHARS; j++) begin
            if (5'(j) < RSV_LEN[i] && w[j] != RSV_TEXT[i][RSV_CHARS-1-j]) begin
               m = 1'b0;
            end
         end
         if (m) begin
            r.hit  = 1'b1;
            r.code = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

// File: design/pascal_subset_lexer.sv
// path: a closed token goes through the queue and then the output register onto rsp
// throughput: one character per cycle unless the queue is full; one rsp beat per cycle
//   if rsp_ready; a two-token character takes two beats, a four-entry queue absorbs them
// reset: synchronous, active high; line count back to one, identifier count to zero,
//   queue and output emptied; the word buffer keeps its contents
module pascal_subset_lexer #(
   parameter int MAX_WORD = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psl_pkg::rsp_type rsp_data
);
   import psl_pkg::*;

   // front to queue: the tokens of one character
   logic       push;
   step_type   push_data;
   // queue to back
   step_type   head;
   q_stat_type q_stat;
   logic       pop;

   // scanner front: classifies each character, tracks the pending word, number or colon,
   // counts lines and identifiers and matches keywords in parallel
   psl_front #(
      .MAX_WORD (MAX_WORD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   // short queue of per-character records, so a stalled output does not stop scanning
   // until it fills
   psl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // back end: splits each record into beats and holds the output register
   psl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // the back end only pops a record that is there
   assert property (@(posedge clock) disable iff (reset) pop |-> q_stat.not_empty)
      else $error("pop from empty queue");

   // the second beat of a character follows straight away on the same line
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |=>
         (rsp_valid && rsp_data.line_number == $past(rsp_data.line_number)))
      else $error("second beat of a character missing or on another line");

   // an error always closes its character and carries an error kind
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.token_kind == KIND_ERROR) |->
         (rsp_data.last && rsp_data.error_kind != ERR_NONE))
      else $error("error beat malformed");

   // identifier numbers only travel with identifiers
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.token_kind != KIND_IDENT) |-> (rsp_data.ident_number == 16'd0))
      else $error("identifier number on a non-identifier beat");

endmodule

// File: design/psl_front.sv
module psl_front #(
   parameter int MAX_WORD = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  psl_pkg::req_type    req_data,
   input  psl_pkg::q_stat_type q_stat,
   output logic                push,
   output psl_pkg::step_type   push_data
);
   import psl_pkg::*;

   localparam int LW = $clog2(MAX_WORD + 2);
   localparam int IW = $clog2(MAX_WORD);

   logic [7:0]    store_ff [MAX_WORD];
   logic [LW-1:0] wlen_ff, wlen_in;
   scan_mode_type mode_ff, mode_in;
   logic [15:0]   ident_ff, ident_in;
   logic [15:0]   line_ff, line_in;
   logic          start_ff, start_in;
   logic          halted_ff, halted_in;

   logic          accept, step, eoi;
   logic [7:0]    c;
   logic          is_letter, is_digit, is_nl;
   sym_type       sym;
   kw_type        kw;
   logic [RSV_CHARS-1:0][7:0] w9;
   logic [15:0]   ident_inc, line_step;

   token_type     tok_i, tok_p, tok_a;
   logic          emit_i, halt_i, word_i;
   scan_mode_type mode_i;
   logic          pend;
   logic          emit_p, do_idle, end_now, skip, word_cont, num_err, assign_now;
   logic          emit_a, emit_b;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign step      = accept && !halted_ff;
   assign eoi       = req_data.end_of_input;
   assign c         = req_data.char_code;
   assign is_letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                      (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   assign is_digit  = (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
   assign is_nl     = (c == CH_NL);
   assign sym       = sym_lookup(c);
   assign ident_inc = (ident_ff != COUNT_MAX) ? ident_ff + 16'd1 : ident_ff;
   assign line_step = (is_nl && line_ff != COUNT_MAX) ? line_ff + 16'd1 : line_ff;

   always_comb begin
      for (int j = 0; j < RSV_CHARS; j++) begin
         w9[j] = store_ff[j];
      end
   end
   assign kw = kw_lookup(w9, 5'(wlen_ff));

   // character seen with nothing pending
   always_comb begin
      tok_i  = '0;
      emit_i = 1'b0;
      mode_i = MODE_IDLE;
      halt_i = 1'b0;
      word_i = 1'b0;
      if (sym.hit) begin
         if (c == CH_COLON) begin
            mode_i = MODE_COLON;
         end else begin
            emit_i     = 1'b1;
            tok_i.kind = SYM_BASE + 6'(sym.idx);
         end
      end else if (is_letter) begin
         mode_i = MODE_WORD;
         word_i = 1'b1;
      end else if (is_digit) begin
         mode_i = MODE_NUMBER;
      end else if (c <= CH_SPACE) begin
         emit_i     = 1'b1;
         tok_i.kind = KIND_ECHO;
         tok_i.echo = c;
      end else begin
         emit_i     = 1'b1;
         tok_i.kind = KIND_ERROR;
         tok_i.err  = ERR_SYMBOL;
         halt_i     = 1'b1;
      end
   end

   // pending token
   always_comb begin
      tok_p = '0;
      pend  = 1'b1;
      unique case (mode_ff)
         MODE_WORD: begin
            if (kw.hit) begin
               tok_p.kind = 6'(kw.code);
            end else begin
               tok_p.kind  = KIND_IDENT;
               tok_p.ident = ident_inc;
            end
         end
         MODE_NUMBER: tok_p.kind = KIND_NUMBER;
         MODE_COLON:  tok_p.kind = KIND_COLON;
         default:     pend = 1'b0;
      endcase
   end

   // decode of what this character does
   always_comb begin
      emit_p     = 1'b0;
      do_idle    = 1'b0;
      end_now    = 1'b0;
      skip       = 1'b0;
      word_cont  = 1'b0;
      num_err    = 1'b0;
      assign_now = 1'b0;
      if (step) begin
         if (eoi) begin
            emit_p  = pend;
            end_now = 1'b1;
         end else if (start_ff && is_nl) begin
            skip = 1'b1;
         end else begin
            unique case (mode_ff)
               MODE_WORD: begin
                  if (is_letter || is_digit) begin
                     word_cont = 1'b1;
                  end else begin
                     emit_p  = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_letter) begin
                     num_err = 1'b1;
                  end else if (!is_digit) begin
                     emit_p  = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               MODE_COLON: begin
                  if (c == CH_EQUAL) begin
                     assign_now = 1'b1;
                  end else begin
                     emit_p  = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               default: do_idle = 1'b1;
            endcase
         end
      end
   end

   // next state
   always_comb begin
      wlen_in   = wlen_ff;
      mode_in   = mode_ff;
      ident_in  = ident_ff;
      line_in   = line_ff;
      start_in  = start_ff;
      halted_in = halted_ff;
      if (step && !eoi) begin
         line_in = line_step;
         if (!skip) begin
            start_in = 1'b0;
         end
      end
      if (end_now || num_err) begin
         mode_in   = MODE_IDLE;
         halted_in = 1'b1;
      end
      if (assign_now) begin
         mode_in = MODE_IDLE;
      end
      if (word_cont && wlen_ff <= LW'(MAX_WORD)) begin
         wlen_in = wlen_ff + LW'(1);
      end
      if (do_idle) begin
         mode_in   = mode_i;
         halted_in = halt_i;
         if (word_i) begin
            wlen_in = LW'(1);
         end
      end
      if (emit_p && mode_ff == MODE_WORD && !kw.hit) begin
         ident_in = ident_inc;
      end
   end

   // outputs toward the queue
   always_comb begin
      tok_a = tok_p;
      if (assign_now) begin
         tok_a      = '0;
         tok_a.kind = KIND_ASSIGN;
      end else if (num_err) begin
         tok_a      = '0;
         tok_a.kind = KIND_ERROR;
         tok_a.err  = ERR_MALFORMED;
      end
      emit_a         = assign_now || num_err || emit_p;
      emit_b         = do_idle && emit_i;
      push           = emit_a || emit_b;
      push_data.two  = emit_a && emit_b;
      push_data.tok0 = emit_a ? tok_a : tok_i;
      push_data.tok1 = tok_i;
      push_data.line = line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff   <= '0;
         mode_ff   <= MODE_IDLE;
         ident_ff  <= '0;
         line_ff   <= 16'd1;
         start_ff  <= 1'b1;
         halted_ff <= 1'b0;
      end else begin
         wlen_ff   <= wlen_in;
         mode_ff   <= mode_in;
         ident_ff  <= ident_in;
         line_ff   <= line_in;
         start_ff  <= start_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_cont && wlen_ff < LW'(MAX_WORD)) begin
         store_ff[wlen_ff[IW-1:0]] <= c;
      end
      if (do_idle && word_i) begin
         store_ff[0] <= c;
      end
   end

endmodule

// File: design/psl_queue.sv
module psl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psl_pkg::step_type   push_data,
   input  logic                pop,
   output psl_pkg::step_type   head,
   output psl_pkg::q_stat_type q_stat
);
   import psl_pkg::*;

   step_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign q_stat.full      = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_stat.not_empty = (cnt_ff != '0);
   assign do_push          = push && !q_stat.full;
   assign do_pop           = pop && q_stat.not_empty;
   assign head             = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + QUEUE_AW'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + QUEUE_AW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: design/psl_back.sv
module psl_back (
   input  logic                clock,
   input  logic                reset,
   input  psl_pkg::step_type   head,
   input  psl_pkg::q_stat_type q_stat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output psl_pkg::rsp_type    rsp_data
);
   import psl_pkg::*;

   logic      valid_ff, valid_in;
   logic      sel_ff, sel_in;
   rsp_type   out_ff, out_in;
   token_type tok;
   logic      load;

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;
   assign load      = !valid_ff || rsp_ready;
   assign tok       = sel_ff ? head.tok1 : head.tok0;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      out_in   = out_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = q_stat.not_empty;
         if (q_stat.not_empty) begin
            out_in.token_kind   = tok.kind;
            out_in.ident_number = tok.ident;
            out_in.echo_char    = tok.echo;
            out_in.error_kind   = tok.err;
            out_in.line_number  = head.line;
            if (head.two && !sel_ff) begin
               out_in.last = 1'b0;
               sel_in      = 1'b1;
            end else begin
               out_in.last = 1'b1;
               sel_in      = 1'b0;
               pop         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
